// ===== design/olids_pkg.sv =====
// Shared constants and types for the ordered list block.
`default_nettype none

package olids_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 6) ? CNT_W : 6;

    localparam logic [3:0] CMD_INS_FRONT = 4'd0;
    localparam logic [3:0] CMD_INS_END   = 4'd1;
    localparam logic [3:0] CMD_INS_POS   = 4'd2;
    localparam logic [3:0] CMD_DEL_FRONT = 4'd3;
    localparam logic [3:0] CMD_DEL_END   = 4'd4;
    localparam logic [3:0] CMD_DEL_POS   = 4'd5;
    localparam logic [3:0] CMD_SEARCH    = 4'd6;
    localparam logic [3:0] CMD_SORT      = 4'd7;
    localparam logic [3:0] CMD_DISPLAY   = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_TAKE_LEFT,
        OP_TAKE_RIGHT,
        OP_TAKE_NEW,
        OP_SORT_LO,
        OP_SORT_HI
    } cell_op_t;

endpackage

`default_nettype wire

// ===== design/olids_cell.sv =====
// One storage cell of the list chain, with its neighbor compare.
`default_nettype none

module olids_cell (
    input  wire logic              clk,
    input  wire olids_pkg::cell_op_t op,
    input  wire logic [31:0]       left_val,
    input  wire logic [31:0]       right_val,
    input  wire logic              left_gt,
    input  wire logic [31:0]       bcast,
    output logic      [31:0]       val,
    output logic                   gt,
    output logic                   match
);

    logic [31:0] val_reg;
    logic [31:0] val_next;

    assign val   = val_reg;
    assign gt    = $signed(val_reg) > $signed(right_val);
    assign match = (val_reg == bcast);

    always_comb
    begin
        val_next = val_reg;
        case (op)
            olids_pkg::OP_TAKE_LEFT:  val_next = left_val;
            olids_pkg::OP_TAKE_RIGHT: val_next = right_val;
            olids_pkg::OP_TAKE_NEW:   val_next = bcast;
            // Lower cell of a compare pair takes the smaller value.
            olids_pkg::OP_SORT_LO:    val_next = gt ? right_val : val_reg;
            olids_pkg::OP_SORT_HI:    val_next = left_gt ? left_val : val_reg;
            default:                  val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

// ===== design/ordered_list_insert_delete_sort_top.sv =====
// Top level of the ordered list: command decode, sequencer and cell chain.
//
// The block keeps up to CAPACITY signed 32-bit values in a chain of cells.
// A command beat is taken on the input channel when in_valid is high and
// in_stall is low; each result beat leaves on the output channel when
// out_valid is high and out_stall is low. One command is worked on at a
// time: in_stall stays high while a search, sort or display runs, and
// while the output register holds a beat that cannot move on.
// Successful inserts and deletes update the chain and count in the cycle of
// acceptance; all of them and unused codes show their result in the next
// cycle. A search compares all cells at once in the search state and
// answers from there. A sort runs CAPACITY odd-even transposition passes,
// one per cycle, then reports from the done state. A display rotates the
// chain once per beat and emits one beat per element. A stall on the output
// holds the current beat and pauses the search, done and display states;
// sort passes go on. Reset empties the list and clears out_valid; cell
// contents are not reset.
`default_nettype none

module ordered_list_insert_delete_sort_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  command,
    input  wire logic [31:0] value,
    input  wire logic [5:0]  position,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [2:0]  status,
    output logic      [31:0] element_value,
    output logic      [4:0]  element_position,
    output logic      [4:0]  length,
    output logic             last
);

    localparam int CAP   = olids_pkg::CAPACITY;
    localparam int IDX_W = olids_pkg::IDX_W;
    localparam int CNT_W = olids_pkg::CNT_W;
    localparam int CMP_W = olids_pkg::CMP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_SORT,
        S_DONE,
        S_DISP
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [31:0]            value_reg, value_next;
    logic [IDX_W-1:0]       pass_reg, pass_next;
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             status_reg, status_next;
    logic [31:0]            evalue_reg, evalue_next;
    logic [4:0]             epos_reg, epos_next;
    logic                   last_reg, last_next;
    logic [4:0]             length_reg, length_next;

    olids_pkg::cell_op_t    cell_op [CAP];
    logic [31:0]            cell_val [CAP];
    logic                   cell_gt [CAP];
    logic                   cell_match [CAP];
    logic [31:0]            bcast;

    logic                   out_free;
    logic                   in_acc;
    logic                   full;
    logic                   pos_ok;
    logic [IDX_W-1:0]       idx;
    logic [CAP-1:0]         hits;
    logic [IDX_W-1:0]       found_idx;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign in_acc   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(CAP));
    assign pos_ok   = (position != 6'd0) && (CMP_W'(position) <= CMP_W'(count_reg));
    assign idx      = IDX_W'(CMP_W'(position) - CMP_W'(1));

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign element_value    = evalue_reg;
    assign element_position = epos_reg;
    assign length           = length_reg;
    assign last             = last_reg;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  bcast = value;
            S_DISP:  bcast = cell_val[0];
            default: bcast = value_reg;
        endcase
    end

    // The cell chain.
    for (genvar g = 0; g < CAP; g++)
    begin : g_cell
        logic [31:0] lv;
        logic [31:0] rv;
        logic        lg;
        if (g == 0)
        begin : g_first
            assign lv = bcast;
            assign lg = 1'b0;
        end
        else
        begin : g_mid
            assign lv = cell_val[g-1];
            assign lg = cell_gt[g-1];
        end
        if (g == CAP - 1)
        begin : g_end
            assign rv = cell_val[g];
        end
        else
        begin : g_inner
            assign rv = cell_val[g+1];
        end
        olids_cell u_cell (
            .clk       (clk),
            .op        (cell_op[g]),
            .left_val  (lv),
            .right_val (rv),
            .left_gt   (lg),
            .bcast     (bcast),
            .val       (cell_val[g]),
            .gt        (cell_gt[g]),
            .match     (cell_match[g])
        );
    end

    // Lowest matching position among the occupied cells.
    always_comb
    begin
        found_idx = '0;
        for (int i = 0; i < CAP; i++)
        begin
            hits[i] = cell_match[i] && (CNT_W'(i) < count_reg);
        end
        for (int i = CAP - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                found_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        value_next     = value_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        evalue_next    = evalue_reg;
        epos_next      = epos_reg;
        last_next      = last_reg;
        length_next    = length_reg;
        for (int i = 0; i < CAP; i++)
        begin
            cell_op[i] = olids_pkg::OP_HOLD;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    value_next     = value;
                    pass_next      = '0;
                    out_valid_next = 1'b1;
                    status_next    = olids_pkg::ST_OK;
                    evalue_next    = '0;
                    epos_next      = '0;
                    last_next      = 1'b1;
                    unique case (command)
                        olids_pkg::CMD_INS_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = olids_pkg::ST_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < CAP; i++)
                                begin
                                    cell_op[i] = (i == 0) ? olids_pkg::OP_TAKE_NEW
                                                          : olids_pkg::OP_TAKE_LEFT;
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        olids_pkg::CMD_INS_END:
                        begin
                            if (full)
                            begin
                                status_next = olids_pkg::ST_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < CAP; i++)
                                begin
                                    if (CNT_W'(i) == count_reg)
                                    begin
                                        cell_op[i] = olids_pkg::OP_TAKE_NEW;
                                    end
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        olids_pkg::CMD_INS_POS:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = olids_pkg::ST_EMPTY;
                            end
                            else if (!pos_ok)
                            begin
                                status_next = olids_pkg::ST_BADPOS;
                            end
                            else if (full)
                            begin
                                status_next = olids_pkg::ST_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < CAP; i++)
                                begin
                                    if (IDX_W'(i) == idx)
                                    begin
                                        cell_op[i] = olids_pkg::OP_TAKE_NEW;
                                    end
                                    else if (IDX_W'(i) > idx)
                                    begin
                                        cell_op[i] = olids_pkg::OP_TAKE_LEFT;
                                    end
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        olids_pkg::CMD_DEL_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = olids_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                for (int i = 0; i < CAP; i++)
                                begin
                                    cell_op[i] = olids_pkg::OP_TAKE_RIGHT;
                                end
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        olids_pkg::CMD_DEL_END:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = olids_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        olids_pkg::CMD_DEL_POS:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = olids_pkg::ST_EMPTY;
                            end
                            else if (!pos_ok)
                            begin
                                status_next = olids_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                for (int i = 0; i < CAP; i++)
                                begin
                                    if (IDX_W'(i) >= idx)
                                    begin
                                        cell_op[i] = olids_pkg::OP_TAKE_RIGHT;
                                    end
                                end
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        olids_pkg::CMD_SEARCH,
                        olids_pkg::CMD_SORT,
                        olids_pkg::CMD_DISPLAY:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = olids_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && out_stall;
                                if (command == olids_pkg::CMD_SEARCH)
                                begin
                                    state_next = S_SRCH;
                                end
                                else if (command == olids_pkg::CMD_SORT)
                                begin
                                    state_next = S_SORT;
                                end
                                else
                                begin
                                    state_next = S_DISP;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = olids_pkg::ST_OK;
                        end
                    endcase
                    length_next = 5'(count_next);
                end
            end
            S_SRCH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    evalue_next    = '0;
                    last_next      = 1'b1;
                    length_next    = 5'(count_reg);
                    if (|hits)
                    begin
                        status_next = olids_pkg::ST_OK;
                        epos_next   = 5'(CNT_W'(found_idx) + CNT_W'(1));
                    end
                    else
                    begin
                        status_next = olids_pkg::ST_NOTFOUND;
                        epos_next   = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_SORT:
            begin
                // Odd-even transposition: pairs start on cells whose index
                // parity matches the pass parity.
                for (int i = 0; i < CAP; i++)
                begin
                    if ((i[0] == pass_reg[0]) && (CNT_W'(i + 1) < count_reg))
                    begin
                        cell_op[i] = olids_pkg::OP_SORT_LO;
                    end
                    else if ((i >= 1) && (i[0] != pass_reg[0]) && (CNT_W'(i) < count_reg))
                    begin
                        cell_op[i] = olids_pkg::OP_SORT_HI;
                    end
                end
                pass_next = pass_reg + IDX_W'(1);
                if (pass_reg == IDX_W'(CAP - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = olids_pkg::ST_OK;
                    evalue_next    = '0;
                    epos_next      = '0;
                    last_next      = 1'b1;
                    length_next    = 5'(count_reg);
                    state_next     = S_IDLE;
                end
            end
            S_DISP:
            begin
                if (out_free)
                begin
                    // Rotate the occupied part of the chain by one; the
                    // list is back in order after the final beat.
                    for (int i = 0; i < CAP; i++)
                    begin
                        if (CNT_W'(i + 1) == count_reg)
                        begin
                            cell_op[i] = olids_pkg::OP_TAKE_NEW;
                        end
                        else if (CNT_W'(i + 1) < count_reg)
                        begin
                            cell_op[i] = olids_pkg::OP_TAKE_RIGHT;
                        end
                    end
                    out_valid_next = 1'b1;
                    status_next    = olids_pkg::ST_OK;
                    evalue_next    = cell_val[0];
                    epos_next      = 5'(CNT_W'(pass_reg) + CNT_W'(1));
                    length_next    = 5'(count_reg);
                    last_next      = (CNT_W'(pass_reg) + CNT_W'(1) == count_reg);
                    pass_next      = pass_reg + IDX_W'(1);
                    if (CNT_W'(pass_reg) + CNT_W'(1) == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        evalue_reg <= evalue_next;
        epos_reg   <= epos_next;
        last_reg   <= last_next;
        length_reg <= length_next;
    end

endmodule

`default_nettype wire

// ===== tb/ordered_list_insert_delete_sort_top_tb.sv =====
// Testbench for the ordered list block: predicts and checks every result beat.
`timescale 1ns / 100ps

module ordered_list_insert_delete_sort_top_tb;

    localparam logic [3:0] CMD_UNUSED_LO = olids_pkg::CMD_DISPLAY + 4'd1;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         PHASE_ITEMS   = 40;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] elem_value;
        logic [4:0]  elem_pos;
        logic [4:0]  len;
        logic        fin;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  command = olids_pkg::CMD_INS_FRONT;
    logic [31:0] value = 32'd0;
    logic [5:0]  position = 6'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] element_value;
    logic [4:0]  element_position;
    logic [4:0]  length;
    logic        last;

    // Shadow copy of the list contents and the expected result beats.
    logic signed [31:0] list_cells [olids_pkg::CAPACITY];
    int                 list_len = 0;
    list_result_t       pending_results [$];

    int send_idle_pct = 17;
    int recv_stall_pct = 48;
    int fail_count = 0;
    int cycle_count = 0;

    ordered_list_insert_delete_sort_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .value            (value),
        .position         (position),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .element_value    (element_value),
        .element_position (element_position),
        .length           (length),
        .last             (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Updates the shadow list for one command and queues its result beats.
    function automatic void apply_list_command(input logic [3:0] cmd,
                                               input logic signed [31:0] val,
                                               input logic [5:0] pos);
        list_result_t       res;
        logic signed [31:0] swap;
        int                 idx;
        int                 i;
        int                 j;
        res = '{olids_pkg::ST_OK, 32'd0, 5'd0, 5'd0, 1'b1};
        case (cmd)
            olids_pkg::CMD_INS_FRONT, olids_pkg::CMD_INS_END, olids_pkg::CMD_INS_POS:
            begin
                if (cmd == olids_pkg::CMD_INS_POS && list_len == 0)
                    res.status = olids_pkg::ST_EMPTY;
                else if (cmd == olids_pkg::CMD_INS_POS && (pos < 1 || pos > list_len))
                    res.status = olids_pkg::ST_BADPOS;
                else if (list_len >= olids_pkg::CAPACITY)
                    res.status = olids_pkg::ST_FULL;
                else
                begin
                    if (cmd == olids_pkg::CMD_INS_FRONT)
                        idx = 0;
                    else if (cmd == olids_pkg::CMD_INS_END)
                        idx = list_len;
                    else
                        idx = pos - 1;
                    for (i = list_len; i > idx; i--)
                        list_cells[i] = list_cells[i - 1];
                    list_cells[idx] = val;
                    list_len++;
                end
            end
            olids_pkg::CMD_DEL_FRONT, olids_pkg::CMD_DEL_END, olids_pkg::CMD_DEL_POS:
            begin
                if (list_len == 0)
                    res.status = olids_pkg::ST_EMPTY;
                else if (cmd == olids_pkg::CMD_DEL_POS && (pos < 1 || pos > list_len))
                    res.status = olids_pkg::ST_BADPOS;
                else
                begin
                    if (cmd == olids_pkg::CMD_DEL_FRONT)
                        idx = 0;
                    else if (cmd == olids_pkg::CMD_DEL_END)
                        idx = list_len - 1;
                    else
                        idx = pos - 1;
                    for (i = idx; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i + 1];
                    list_len--;
                end
            end
            olids_pkg::CMD_SEARCH:
            begin
                if (list_len == 0)
                    res.status = olids_pkg::ST_EMPTY;
                else
                begin
                    res.status = olids_pkg::ST_NOTFOUND;
                    for (i = list_len - 1; i >= 0; i--)
                    begin
                        if (list_cells[i] == val)
                        begin
                            res.status = olids_pkg::ST_OK;
                            res.elem_pos = 5'(i + 1);
                        end
                    end
                end
            end
            olids_pkg::CMD_SORT:
            begin
                if (list_len == 0)
                    res.status = olids_pkg::ST_EMPTY;
                for (i = 1; i < list_len; i++)
                    for (j = 0; j + 1 < list_len; j++)
                        if (list_cells[j] > list_cells[j + 1])
                        begin
                            swap = list_cells[j];
                            list_cells[j] = list_cells[j + 1];
                            list_cells[j + 1] = swap;
                        end
            end
            olids_pkg::CMD_DISPLAY:
            begin
                if (list_len == 0)
                    res.status = olids_pkg::ST_EMPTY;
                else
                begin
                    for (i = 0; i < list_len; i++)
                    begin
                        res.elem_value = list_cells[i];
                        res.elem_pos = 5'(i + 1);
                        res.len = 5'(list_len);
                        res.fin = (i + 1 == list_len);
                        pending_results.push_back(res);
                    end
                    return;
                end
            end
            default:
            begin
            end
        endcase
        res.len = 5'(list_len);
        pending_results.push_back(res);
    endfunction

    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (actual !== expected)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, expected, actual);
            fail_count++;
        end
    endtask

    // Receiver: random stalls, and each accepted beat is checked in order.
    always @(posedge clk)
    begin
        list_result_t exp_res;
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, status %0d, value %0h", $time,
                         status, element_value);
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                check_field("status", exp_res.status, status);
                check_field("element_value", exp_res.elem_value, element_value);
                check_field("element_position", exp_res.elem_pos, element_position);
                check_field("length", exp_res.len, length);
                check_field("last", exp_res.fin, last);
            end
        end
    end

    task automatic send_command(input logic [3:0] cmd, input logic [31:0] val,
                                input logic [5:0] pos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        value <= val;
        position <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_list_command(cmd, val, pos);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_list();
        logic [3:0] empty_cmds [8];
        int         k;
        empty_cmds = '{olids_pkg::CMD_DEL_FRONT, olids_pkg::CMD_DEL_END,
                       olids_pkg::CMD_DEL_POS, olids_pkg::CMD_SEARCH,
                       olids_pkg::CMD_SORT, olids_pkg::CMD_DISPLAY,
                       olids_pkg::CMD_INS_POS, CMD_UNUSED_LO};
        for (k = 0; k < 8; k++)
            send_command(empty_cmds[k], 32'd0, 6'd1);
    endtask

    // Search must scan the whole list, not only the head.
    task automatic test_insert_search();
        send_command(olids_pkg::CMD_INS_END, 32'd5, 6'd0);
        send_command(olids_pkg::CMD_SORT, 32'd0, 6'd0);
        send_command(olids_pkg::CMD_SEARCH, 32'd5, 6'd0);
        send_command(olids_pkg::CMD_SEARCH, -32'sd5, 6'd0);
        send_command(olids_pkg::CMD_INS_FRONT, 32'h7FFF_FFFF, 6'd0);
        send_command(olids_pkg::CMD_INS_POS, 32'h8000_0000, 6'd2);
        send_command(olids_pkg::CMD_SEARCH, 32'd5, 6'd0);
    endtask

    task automatic test_position_limits();
        send_command(olids_pkg::CMD_INS_POS, 32'd7, 6'd0);
        send_command(olids_pkg::CMD_INS_POS, 32'd7, 6'd63);
        send_command(olids_pkg::CMD_INS_POS, 32'd0, 6'd3);
        send_command(olids_pkg::CMD_DEL_POS, 32'd0, 6'd0);
        send_command(olids_pkg::CMD_DEL_POS, 32'd0, 6'd5);
        send_command(olids_pkg::CMD_DEL_POS, 32'd0, 6'd2);
    endtask

    task automatic test_sort_display();
        send_command(olids_pkg::CMD_DISPLAY, 32'd0, 6'd0);
        send_command(olids_pkg::CMD_SORT, 32'd0, 6'd0);
        send_command(olids_pkg::CMD_DISPLAY, 32'd0, 6'd0);
        send_command(CMD_UNUSED_HI, 32'hFFFF_FFFF, 6'd63);
        send_command(olids_pkg::CMD_DEL_END, 32'd0, 6'd0);
    endtask

    // Alternates between growing and shrinking the list so that both the
    // full and the empty list are reached many times.
    task automatic test_random(input int n_items);
        logic [3:0]  cmd;
        logic [31:0] val;
        logic [5:0]  pos;
        int          roll;
        int          n;
        bit          grow;
        grow = 1'b0;
        for (n = 0; n < n_items; n++)
        begin
            if (n % PHASE_ITEMS == 0)
                grow = ~grow;
            roll = $urandom_range(99);
            if (roll < 4)
                cmd = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
            else if (roll < 12)
                cmd = olids_pkg::CMD_SEARCH;
            else if (roll < 18)
                cmd = olids_pkg::CMD_SORT;
            else if (roll < 24)
                cmd = olids_pkg::CMD_DISPLAY;
            else if ((roll < 85) == grow)
                cmd = 4'($urandom_range(olids_pkg::CMD_INS_POS, olids_pkg::CMD_INS_FRONT));
            else
                cmd = 4'($urandom_range(olids_pkg::CMD_DEL_POS, olids_pkg::CMD_DEL_FRONT));
            case ($urandom_range(3))
                0: val = $urandom;
                1: val = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: val = $signed($urandom_range(6)) - 3;
            endcase
            if (cmd == olids_pkg::CMD_SEARCH && list_len > 0 && $urandom_range(1))
                val = list_cells[$urandom_range(list_len - 1)];
            if ($urandom_range(9) == 0)
                pos = 6'($urandom);
            else
                pos = 6'($urandom_range(list_len + 1));
            send_command(cmd, val, pos);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_insert_search();
        test_position_limits();
        test_sort_display();
        test_random(78);
        wait_for_results();
        send_idle_pct = 48;
        recv_stall_pct = 17;
        test_random(78);
        wait_for_results();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(78);
        wait_for_results();
        repeat (olids_pkg::CAPACITY + 4) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== ordered_list_insert_delete_sort_top.f =====
design/olids_pkg.sv
design/olids_cell.sv
design/ordered_list_insert_delete_sort_top.sv
tb/ordered_list_insert_delete_sort_top_tb.sv
